@@ design/bbrf_pkg.sv @@
// Package for the byte-budgeted record FIFO: constants, entry, result and request types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbrf_pkg;
   localparam int EntryDepth     = 32;
   localparam int RecordOverhead = 32;
   localparam int IdxW           = $clog2(EntryDepth);
   localparam int CntW           = $clog2(EntryDepth + 1);
   localparam logic [30:0] BytesMax = 31'h7FFF_FFFF;

   localparam logic [1:0] KIND_PUSH   = 2'd0;
   localparam logic [1:0] KIND_DRAIN  = 2'd1;
   localparam logic [1:0] KIND_REPLAY = 2'd2;
   localparam logic [1:0] KIND_RESIZE = 2'd3;

   typedef struct packed {
      logic [15:0] size;
      logic [31:0] code;
      logic [31:0] payload;
      logic [31:0] seq;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef struct packed {
      logic        has_record;
      logic [31:0] out_code;
      logic [15:0] out_size;
      logic [31:0] out_payload;
      logic [31:0] out_id;
      logic        accepted;
      logic        full_flag;
      logic [30:0] bytes_used;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] record_size;
      logic [31:0] record_code;
      logic [31:0] payload_ref;
      logic [31:0] amount;
   } request_type;
endpackage
`default_nettype wire

@@ design/bbrf_if.sv @@
// Valid/ready channel interfaces for requests, results and the control register.
// Depends on bbrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bbrf_req_if;
   import bbrf_pkg::*;
   logic        valid;
   logic        ready;
   request_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bbrf_rsp_if;
   import bbrf_pkg::*;
   logic       valid;
   logic       ready;
   result_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bbrf_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/bbrf_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bbrf_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/byte_budget_record_fifo.sv @@
// Top level of the byte-budgeted record FIFO: control sequencer around one entry RAM.
// Depends on bbrf_pkg, bbrf_if and bbrf_ram.
`timescale 1ns / 1ps
`default_nettype none
// One request is handled at a time. A push that fits passes through the store
// state (fit check and entry write), then the done state (result load), before
// its result is offered. Each eviction adds the evict-read and evict states,
// since the oldest entry's size must be read from the entry RAM (registered
// read) before the byte count can be reduced. Drain and replay first read the
// head entry, then offer one record per cycle; while the result register is
// stalled the stream holds and the same entry is read again. An empty drain or
// replay, or a replay with a zero limit, goes from the stream state to the done
// state, which offers its status result. Resize checks the budget in evict-read,
// visits evict and evict-read per evicted record, and loads its result in done.
// Results leave through one output register; a new request is taken only
// after the last result of the previous one has been transferred.
// The entry RAM has no reset; only held entries are ever used.
module byte_budget_record_fifo (
   input wire logic  clock,
   input wire logic  reset,
   bbrf_req_if.sink  req,
   bbrf_rsp_if.source rsp,
   bbrf_csr_if.sink  csr
);
   import bbrf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVICT_RD, ST_EVICT, ST_STORE, ST_STREAM, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   request_type      req_ff, req_in;
   logic             stop_ff;
   logic [IdxW-1:0]  head_ff, head_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [30:0]      held_ff, held_in;
   logic [30:0]      budget_ff, budget_in;
   logic [31:0]      seq_ff, seq_in;
   logic             ovf_ff, ovf_in;
   logic [CntW-1:0]  pos_ff, pos_in;      // stream position
   logic [32:0]      sent_ff, sent_in;    // replay byte sum
   logic             acc_ff, acc_in;
   logic             rdv_ff, rdv_in;      // RAM read data valid for pos_ff
   logic             out_v_ff, out_v_in;
   result_type       out_ff, out_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   logic [EntryW-1:0] rd_raw;

   bbrf_ram #(.Width(EntryW), .Depth(EntryDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   logic        out_free;
   logic [16:0] charge_new, charge_old;
   logic [32:0] need;
   logic        no_fit, full;
   logic        amt_neg;
   logic [31:0] amt;
   logic        last_rec;

   always_comb begin
      out_free   = !out_v_ff || rsp.ready;
      amt        = req_ff.amount;
      amt_neg    = amt[31];
      charge_new = {1'b0, req_ff.record_size} + 17'(RecordOverhead);
      charge_old = {1'b0, rd_data.size} + 17'(RecordOverhead);
      need       = {2'b0, held_ff} + {16'b0, charge_new};
      full       = count_ff >= CntW'(EntryDepth);
      no_fit     = full || (need > {2'b0, budget_ff});
      last_rec   = 1'b0;

      state_in = state_ff;
      req_in   = req_ff;
      head_in  = head_ff;
      count_in = count_ff;
      held_in  = held_ff;
      budget_in = budget_ff;
      seq_in   = seq_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      sent_in  = sent_ff;
      acc_in   = acc_ff;
      rdv_in   = 1'b0;
      out_v_in = out_v_ff && !rsp.ready;
      out_in   = out_ff;
      wr_en    = 1'b0;
      wr_addr  = IdxW'(head_ff + IdxW'(count_ff));
      wr_data  = '{size: req_ff.record_size, code: req_ff.record_code,
                   payload: req_ff.payload_ref, seq: seq_ff};
      rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               req_in  = req.data;
               acc_in  = 1'b0;
               pos_in  = '0;
               sent_in = '0;
               state_in = ST_STORE;
               case (req.data.kind)
                  KIND_PUSH: state_in = ST_STORE;
                  KIND_DRAIN, KIND_REPLAY: state_in = ST_STREAM;
                  default: state_in = ST_EVICT_RD;
               endcase
            end
         end
         ST_STORE: begin
            // push decision
            if (budget_ff == '0 || req_ff.record_size == '0) begin
               state_in = ST_DONE;
            end else if (no_fit && stop_ff) begin
               ovf_in = 1'b1;
               state_in = ST_DONE;
            end else if (no_fit && count_ff != '0) begin
               ovf_in = 1'b1;
               state_in = ST_EVICT_RD;
            end else begin
               if (no_fit) ovf_in = 1'b1;
               wr_en    = 1'b1;
               seq_in   = seq_ff + 32'd1;
               count_in = count_ff + CntW'(1);
               held_in  = (need > {2'b0, BytesMax}) ? BytesMax : need[30:0];
               acc_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_EVICT_RD: begin
            // resize entry check; push always evicts here
            if (req_ff.kind == KIND_RESIZE &&
                (amt_neg || amt[30:0] == budget_ff)) begin
               state_in = ST_DONE;
            end else if (req_ff.kind == KIND_RESIZE &&
                         (count_ff == '0 || held_ff <= amt[30:0])) begin
               budget_in = amt[30:0];
               state_in  = ST_DONE;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if ({14'b0, charge_old} > held_ff) begin
               count_in = '0;
               head_in  = '0;
               held_in  = '0;
               ovf_in   = 1'b0;
            end else begin
               held_in  = held_ff - {14'b0, charge_old};
               head_in  = head_ff + IdxW'(1);
               count_in = count_ff - CntW'(1);
            end
            state_in = (req_ff.kind == KIND_PUSH) ? ST_STORE : ST_EVICT_RD;
            if (req_ff.kind == KIND_RESIZE && count_in == '0) begin
               budget_in = amt[30:0];
               state_in  = ST_DONE;
            end
         end
         ST_STREAM: begin
            rd_addr = IdxW'(head_ff + IdxW'(pos_ff));
            if (count_ff == '0 || (req_ff.kind == KIND_REPLAY && amt == '0)) begin
               // nothing to emit: one status result; an empty drain still clears
               if (req_ff.kind == KIND_DRAIN) begin
                  count_in = '0; head_in = '0; held_in = '0;
                  seq_in = '0; ovf_in = 1'b0;
               end
               state_in = ST_DONE;
            end else if (!rdv_ff) begin
               rdv_in = 1'b1;
            end else if (out_free) begin
               // pos_ff record is in rd_data; its last flag is known right here
               sent_in  = sent_ff + {17'b0, rd_data.size};
               last_rec = ((pos_ff + CntW'(1)) == count_ff) ||
                          (req_ff.kind == KIND_REPLAY && !amt_neg &&
                           sent_in > {1'b0, amt});
               out_in = '{has_record: 1'b1, out_code: rd_data.code,
                          out_size: rd_data.size, out_payload: rd_data.payload,
                          out_id: rd_data.seq, accepted: 1'b0,
                          full_flag: ovf_ff, bytes_used: held_ff, last: last_rec};
               // drain reports the emptied state on every record
               if (req_ff.kind == KIND_DRAIN) begin
                  out_in.full_flag  = 1'b0;
                  out_in.bytes_used = '0;
               end
               out_v_in = 1'b1;
               pos_in   = pos_ff + CntW'(1);
               if (last_rec) begin
                  if (req_ff.kind == KIND_DRAIN) begin
                     count_in = '0; head_in = '0; held_in = '0;
                     seq_in = '0; ovf_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = IdxW'(head_ff + IdxW'(pos_ff) + IdxW'(1));
                  rdv_in  = 1'b1;
               end
            end else begin
               // stalled: the same entry is read again
               rdv_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in = '{has_record: 1'b0, out_code: '0, out_size: '0,
                          out_payload: '0, out_id: '0, accepted: acc_ff,
                          full_flag: ovf_ff, bytes_used: held_ff, last: 1'b1};
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         stop_ff   <= 1'b0;
         head_ff   <= '0;
         count_ff  <= '0;
         held_ff   <= '0;
         budget_ff <= '0;
         seq_ff    <= '0;
         ovf_ff    <= 1'b0;
         out_v_ff  <= 1'b0;
         rdv_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr.valid) stop_ff <= csr.data;
         head_ff   <= head_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
         budget_ff <= budget_in;
         seq_ff    <= seq_in;
         ovf_ff    <= ovf_in;
         out_v_ff  <= out_v_in;
         rdv_ff    <= rdv_in;
      end
      req_ff  <= req_in;
      pos_ff  <= pos_in;
      sent_ff <= sent_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end
endmodule
`default_nettype wire

@@ design/bbrf_checker.sv @@
// Port-level checker for byte_budget_record_fifo, bound to the top level.
// Depends on the byte_budget_record_fifo top level and its bbrf_if ports.
`timescale 1ns / 1ps
`default_nettype none
module bbrf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic rsp_has_record,
   input wire logic rsp_accepted
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");
   a_acc_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_has_record && rsp_last)
      else $error("accepted on a record result");
   a_blank_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_record |-> rsp_last)
      else $error("status result not last");
endmodule

bind byte_budget_record_fifo bbrf_checker u_bbrf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last(rsp.data.last), .rsp_has_record(rsp.data.has_record),
   .rsp_accepted(rsp.data.accepted)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for byte_budget_record_fifo: directed table, then random traffic.
// Depends on bbrf_pkg, the bbrf_if channel interfaces and the design top level.
`timescale 1ns / 1ps

module testbench;
   import bbrf_pkg::*;

   // ---------------------------------------------------------------------------
   // Clock, reset, channels
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;   // 4 ns period

   bbrf_req_if req_ch ();
   bbrf_rsp_if rsp_ch ();
   bbrf_csr_if csr_ch ();

   byte_budget_record_fifo uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // ---------------------------------------------------------------------------
   // Shadow copy of the record queue, used to work out expected results
   // ---------------------------------------------------------------------------
   logic [15:0] shadow_size    [EntryDepth];
   logic [31:0] shadow_code    [EntryDepth];
   logic [31:0] shadow_payload [EntryDepth];
   logic [31:0] shadow_seq     [EntryDepth];
   int          shadow_head;
   int          shadow_count;
   longint      shadow_bytes;
   longint      shadow_budget;
   logic [31:0] shadow_next_seq;
   bit          shadow_full;
   bit          shadow_stop;

   // ring of expected results, oldest at exp_rd
   localparam int ExpDepth = 256;
   result_type  expected_results [ExpDepth];
   int          exp_wr = 0;
   int          exp_rd = 0;

   // run statistics
   int mismatches    = 0;
   int results_seen  = 0;
   int records_seen  = 0;
   int pushes_stored = 0;
   int kind_count [4];
   longint cycles = 0;

   // idle percentages for the two sides, changed per phase
   int send_idle = 0;
   int recv_idle = 0;

   // remove the oldest record; a charge above the byte count wipes the queue
   task automatic evict_oldest();
      longint charge;
      if (shadow_count == 0) return;
      charge = longint'(shadow_size[shadow_head]) + RecordOverhead;
      if (charge > shadow_bytes) begin
         shadow_count = 0;
         shadow_head  = 0;
         shadow_bytes = 0;
         shadow_full  = 1'b0;
         return;
      end
      shadow_bytes -= charge;
      shadow_head   = (shadow_head + 1) % EntryDepth;
      shadow_count--;
   endtask

   // apply one request to the shadow queue and queue up the results it causes
   task automatic predict_results(request_type r);
      result_type outs [EntryDepth];
      int n_outs;
      result_type one;
      longint amt;
      longint charge;
      longint sent;
      int slot;
      bit store;
      bit acc;
      n_outs = 0;
      amt = longint'($signed(r.amount));
      acc = 1'b0;
      case (r.kind)
         KIND_PUSH: begin
            if (shadow_budget != 0 && r.record_size != 0) begin
               charge = longint'(r.record_size) + RecordOverhead;
               store  = 1'b1;
               if (shadow_stop) begin
                  if (shadow_count >= EntryDepth || shadow_bytes + charge > shadow_budget) begin
                     shadow_full = 1'b1;
                     store = 1'b0;
                  end
               end else begin
                  while (shadow_count >= EntryDepth || shadow_bytes + charge > shadow_budget) begin
                     shadow_full = 1'b1;
                     evict_oldest();
                     if (shadow_count == 0) break;
                  end
               end
               if (store) begin
                  slot = (shadow_head + shadow_count) % EntryDepth;
                  shadow_size[slot]    = r.record_size;
                  shadow_code[slot]    = r.record_code;
                  shadow_payload[slot] = r.payload_ref;
                  shadow_seq[slot]     = shadow_next_seq;
                  shadow_next_seq++;
                  shadow_count++;
                  shadow_bytes += charge;
                  if (shadow_bytes > longint'(BytesMax)) shadow_bytes = longint'(BytesMax);
                  acc = 1'b1;
               end
            end
         end
         KIND_DRAIN, KIND_REPLAY: begin
            if (r.kind == KIND_DRAIN || amt != 0) begin
               sent = 0;
               for (int i = 0; i < shadow_count; i++) begin
                  slot = (shadow_head + i) % EntryDepth;
                  one = '0;
                  one.has_record  = 1'b1;
                  one.out_code    = shadow_code[slot];
                  one.out_size    = shadow_size[slot];
                  one.out_payload = shadow_payload[slot];
                  one.out_id      = shadow_seq[slot];
                  outs[n_outs] = one;
                  n_outs++;
                  sent += shadow_size[slot];
                  if (r.kind == KIND_REPLAY && amt > 0 && sent > amt) break;
               end
            end
            if (r.kind == KIND_DRAIN) begin
               shadow_count    = 0;
               shadow_head     = 0;
               shadow_bytes    = 0;
               shadow_next_seq = '0;
               shadow_full     = 1'b0;
            end
         end
         default: begin   // resize
            if (amt >= 0 && amt != shadow_budget) begin
               while (shadow_bytes > amt) begin
                  evict_oldest();
                  if (shadow_count == 0) break;
               end
               shadow_budget = amt;
            end
         end
      endcase
      if (n_outs == 0) begin
         one = '0;
         one.accepted = acc;
         outs[0] = one;
         n_outs = 1;
      end
      for (int k = 0; k < n_outs; k++) begin
         outs[k].full_flag  = shadow_full;
         outs[k].bytes_used = shadow_bytes[30:0];
         outs[k].last       = (k == n_outs - 1);
         expected_results[exp_wr % ExpDepth] = outs[k];
         exp_wr++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure, compare against the oldest expectation
   // ---------------------------------------------------------------------------
   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         results_seen++;
         if (got.has_record) records_seen++;
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result transfer %h", $realtime, got);
         end else begin
            want = expected_results[exp_rd % ExpDepth];
            exp_rd++;
            if (got.has_record !== want.has_record || got.out_code !== want.out_code ||
                got.out_size !== want.out_size || got.out_payload !== want.out_payload ||
                got.out_id !== want.out_id || got.accepted !== want.accepted ||
                got.full_flag !== want.full_flag || got.bytes_used !== want.bytes_used ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("  expected rec=%b code=%h size=%h pay=%h id=%h acc=%b full=%b bytes=%0d last=%b",
                           want.has_record, want.out_code, want.out_size, want.out_payload,
                           want.out_id, want.accepted, want.full_flag, want.bytes_used, want.last);
                  $display("  actual   rec=%b code=%h size=%h pay=%h id=%h acc=%b full=%b bytes=%0d last=%b",
                           got.has_record, got.out_code, got.out_size, got.out_payload,
                           got.out_id, got.accepted, got.full_flag, got.bytes_used, got.last);
               end
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   // watchdog: generous bound on the slowest legal run
   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = 1'b0;
   end

   // one request transfer; valid is left high so back-to-back items never toggle it
   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      kind_count[r.kind]++;
      predict_results(r);
   endtask

   // let the block go quiet: no request pending, every result back
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_stop_when_full(bit value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      shadow_stop = value;
      @(posedge clock);
   endtask

   function automatic request_type make_request(logic [1:0] kind, logic [15:0] size,
                                                logic [31:0] code, logic [31:0] pay,
                                                logic [31:0] amount);
      request_type r;
      r.kind        = kind;
      r.record_size = size;
      r.record_code = code;
      r.payload_ref = pay;
      r.amount      = amount;
      return r;
   endfunction

   // random item: mostly pushes with small sizes, budgets that let the queue fill
   function automatic request_type random_request();
      int pick;
      logic [15:0] size;
      logic [31:0] amount;
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0:       size = 16'd0;
         1:       size = 16'hFFFF;
         2:       size = 16'($urandom);
         default: size = 16'($urandom_range(1, 200));
      endcase
      if (pick < 62) begin
         amount = $urandom;
         return make_request(KIND_PUSH, size, $urandom, $urandom, amount);
      end else if (pick < 68) begin
         return make_request(KIND_DRAIN, size, $urandom, $urandom, $urandom);
      end else if (pick < 84) begin
         case ($urandom_range(5))
            0:       amount = 32'hFFFF_FFFF;
            1:       amount = '0;
            2:       amount = $urandom;
            default: amount = $urandom_range(0, 600);
         endcase
         return make_request(KIND_REPLAY, size, $urandom, $urandom, amount);
      end else begin
         case ($urandom_range(7))
            0:       amount = $urandom | 32'h8000_0000;   // negative, ignored
            1:       amount = '0;
            2:       amount = $urandom & 32'h7FFF_FFFF;
            3, 4:    amount = $urandom_range(200000, 4000000);
            default: amount = $urandom_range(100, 3000);
         endcase
         return make_request(KIND_RESIZE, size, $urandom, $urandom, amount);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table: rows with a typed-in result are checked against that literal
   // (single status result); the rest go through the predictor.
   // ---------------------------------------------------------------------------
   typedef struct {
      request_type rq;
      bit          typed;
      bit          lit_accepted;
      bit          lit_full;
      logic [30:0] lit_bytes;
   } table_row_type;

   table_row_type directed [32];
   int            n_directed = 0;

   function automatic table_row_type row(request_type rq, bit typed = 1'b0, bit acc = 1'b0,
                                         bit full = 1'b0, logic [30:0] bytes = '0);
      table_row_type t;
      t.rq = rq; t.typed = typed; t.lit_accepted = acc; t.lit_full = full; t.lit_bytes = bytes;
      return t;
   endfunction

   task automatic add_row(table_row_type t);
      directed[n_directed] = t;
      n_directed++;
   endtask

   initial begin
      result_type lit;
      for (int i = 0; i < EntryDepth; i++) begin
         shadow_size[i] = '0; shadow_code[i] = '0; shadow_payload[i] = '0; shadow_seq[i] = '0;
      end
      shadow_head = 0; shadow_count = 0; shadow_bytes = 0; shadow_budget = 0;
      shadow_next_seq = '0; shadow_full = 1'b0; shadow_stop = 1'b0;
      foreach (kind_count[k]) kind_count[k] = 0;

      // zero budget: push ignored; empty drain/replay; negative resize ignored; then a budget of 400
      add_row(row(make_request(KIND_PUSH, 16'd100, 32'h1, 32'h2, 32'd0), 1));
      add_row(row(make_request(KIND_DRAIN, 16'd0, 32'h0, 32'h0, 32'd0), 1));
      add_row(row(make_request(KIND_REPLAY, 16'd0, 32'h0, 32'h0, 32'hFFFF_FFFF), 1));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'h8000_0000), 1));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'd400), 1));
      // smallest record, then one bigger than the whole budget stored once emptied
      add_row(row(make_request(KIND_PUSH, 16'd1, 32'hFFFF_FFFF, 32'h0, 32'd0),
                  1, 1, 0, 31'd33));
      add_row(row(make_request(KIND_PUSH, 16'hFFFF, 32'h0, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF), 1, 1, 1, 31'd65567));
      add_row(row(make_request(KIND_PUSH, 16'd0, 32'h5, 32'h5, 32'd0)));
      add_row(row(make_request(KIND_PUSH, 16'd50, 32'hA5A5_5A5A, 32'h1234_5678, 32'd0)));
      add_row(row(make_request(KIND_PUSH, 16'd60, 32'h5A5A_A5A5, 32'h8765_4321, 32'd0)));
      add_row(row(make_request(KIND_PUSH, 16'd70, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 32'd0)));
      add_row(row(make_request(KIND_REPLAY, 16'd0, 32'h0, 32'h0, 32'd0)));
      add_row(row(make_request(KIND_REPLAY, 16'd0, 32'h0, 32'h0, 32'd55)));
      add_row(row(make_request(KIND_REPLAY, 16'd0, 32'h0, 32'h0, 32'h7FFF_FFFF)));
      add_row(row(make_request(KIND_REPLAY, 16'd0, 32'h0, 32'h0, 32'h8000_0000)));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'd400)));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'd100)));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'h7FFF_FFFF)));
      for (int i = 0; i < 3; i++)
         add_row(row(make_request(KIND_PUSH, 16'(i + 3), 32'(i), 32'(~i), 32'd0)));
      add_row(row(make_request(KIND_DRAIN, 16'd0, 32'h0, 32'h0, 32'd0)));
      add_row(row(make_request(KIND_DRAIN, 16'd0, 32'h0, 32'h0, 32'd0), 1));
      add_row(row(make_request(KIND_RESIZE, 16'd0, 32'h0, 32'h0, 32'd0), 1));

      // reset, then the register to its reset value
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_stop_when_full(1'b0);

      for (int i = 0; i < n_directed; i++) begin
         send_request(directed[i].rq);
         if (directed[i].typed) begin
            // the predictor must agree with the literal; the literal is what gets checked
            lit = '0;
            lit.accepted   = directed[i].lit_accepted;
            lit.full_flag  = directed[i].lit_full;
            lit.bytes_used = directed[i].lit_bytes;
            lit.last       = 1'b1;
            exp_wr--;
            expected_results[exp_wr % ExpDepth] = lit;
            exp_wr++;
         end
      end

      // refuse mode, sender idles 38% / receiver 56%
      wait_quiet();
      write_stop_when_full(1'b1);
      send_idle = 38; recv_idle = 56;
      repeat (105) send_request(random_request());

      // drop-oldest mode, idling swapped
      wait_quiet();
      write_stop_when_full(1'b0);
      send_idle = 56; recv_idle = 38;
      repeat (105) send_request(random_request());

      // refuse mode again, full throughput
      wait_quiet();
      write_stop_when_full(1'b1);
      send_idle = 0; recv_idle = 0;
      repeat (105) send_request(random_request());

      wait_quiet();
      repeat (40) @(posedge clock);

      $display("Covered %0d pushes (%0d stored), %0d drains, %0d replays, %0d resizes",
               kind_count[KIND_PUSH], pushes_stored, kind_count[KIND_DRAIN],
               kind_count[KIND_REPLAY], kind_count[KIND_RESIZE]);
      $display("in both full-queue modes; %0d results checked, %0d with records, %0d mismatches",
               results_seen, records_seen, mismatches);
      if (mismatches == 0 && exp_wr == exp_rd) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // count stored pushes as they come back
   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.data.accepted) pushes_stored++;

endmodule

@@ sim.f @@
design/bbrf_pkg.sv
design/bbrf_if.sv
design/bbrf_ram.sv
design/byte_budget_record_fifo.sv
design/bbrf_checker.sv
tb/sv/testbench.sv
